// ===== hdl/decimal_text_to_int64_assert.svh =====
// assertion macros for the decimal text to int64 block
// taken in by the files that check their own logic
`ifndef DECIMAL_TEXT_TO_INT64_ASSERT_SVH
`define DECIMAL_TEXT_TO_INT64_ASSERT_SVH
`ifndef SYNTH
`define DTTI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtti: implication check failed");
`define DTTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtti: next-cycle check failed");
`else
`define DTTI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DTTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/dtti_pkg.sv =====
// shared types and constants for the decimal text to int64 block
// no dependencies
package dtti_pkg;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_EMPTY_SIGN = 3'd2,
		ST_BAD_CHAR   = 3'd3,
		ST_OVERFLOW   = 3'd4,
		ST_UNDERFLOW  = 3'd5
	} status_t;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] U_LIMIT   = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [63:0] magnitude;
		logic        negative;
		status_t     status;
	} raw_res_t;

	typedef struct packed {
		logic [63:0] value_bits;
		status_t     status;
	} out_res_t;

endpackage

// ===== hdl/dtti_ifs.sv =====
// handshake channels of the decimal text to int64 block
// depends on dtti_pkg
interface dtti_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       last;

	modport source (output valid, char_code, has_char, last, input ready);
	modport sink (input valid, char_code, has_char, last, output ready);
endinterface

interface dtti_res_if;
	logic              valid;
	logic              ready;
	logic [63:0]       value_bits;
	dtti_pkg::status_t status;

	modport source (output valid, value_bits, status, input ready);
	modport sink (input valid, value_bits, status, output ready);
endinterface

interface dtti_cfg_if;
	logic valid;
	logic ready;
	logic signed_mode;

	modport source (output valid, signed_mode, input ready);
	modport sink (input valid, signed_mode, output ready);
endinterface

// ===== hdl/dtti_parse.sv =====
// input register, per-string parse state and raw result register
// depends on dtti_pkg, dtti_ifs and the assertion header
`include "decimal_text_to_int64_assert.svh"

module dtti_parse (
	input  logic               clk,
	input  logic               arst_n,
	dtti_char_if.sink          chars,
	dtti_cfg_if.sink           cfg,
	output dtti_pkg::raw_res_t res,
	output logic               res_valid,
	input  logic               res_ready
);
	import dtti_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        has_char_s1;
	logic        last_s1;

	logic        signed_mode_q;
	logic [63:0] acc_q;
	logic        neg_q;
	logic        first_q;
	logic        digits_q;
	logic        sign_q;
	status_t     err_q;

	logic        res_valid_s2;
	raw_res_t    res_s2;

	logic        slot_free;
	logic        adv;
	logic        is_sign;
	logic        is_digit;
	logic [3:0]  digit;
	logic [67:0] sum;
	logic [63:0] limit;
	logic        ovf;

	logic [63:0] acc_n;
	logic        neg_n;
	logic        digits_n;
	logic        sign_n;
	status_t     err_n;
	raw_res_t    res_n;

	assign slot_free   = !res_valid_s2 || res_ready;
	assign adv         = valid_s1 && (!last_s1 || slot_free);
	assign chars.ready = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;
	assign res         = res_s2;
	assign res_valid   = res_valid_s2;

	// item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1     <= chars.char_code;
			has_char_s1 <= chars.has_char;
			last_s1     <= chars.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			signed_mode_q <= cfg.signed_mode;
		end
	end

	// accumulate times ten plus digit, checked against the exact limit
	always_comb begin
		is_sign  = (char_s1 == CH_MINUS) || (char_s1 == CH_PLUS);
		is_digit = char_s1 inside {[CH_ZERO:CH_NINE]};
		digit    = 4'(char_s1 - CH_ZERO);
		sum      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, digit};
		if (!signed_mode_q) begin
			limit = U_LIMIT;
		end else if (neg_q) begin
			limit = NEG_LIMIT;
		end else begin
			limit = POS_LIMIT;
		end
		ovf = sum > {4'd0, limit};
	end

	always_comb begin
		acc_n    = acc_q;
		neg_n    = neg_q;
		digits_n = digits_q;
		sign_n   = sign_q;
		err_n    = err_q;
		if (has_char_s1 && err_q == ST_OK) begin
			if (first_q && signed_mode_q && is_sign) begin
				sign_n = 1'b1;
				neg_n  = (char_s1 == CH_MINUS);
			end else if (!is_digit) begin
				err_n = ST_BAD_CHAR;
			end else if (ovf) begin
				err_n = neg_q ? ST_UNDERFLOW : ST_OVERFLOW;
			end else begin
				acc_n    = sum[63:0];
				digits_n = 1'b1;
			end
		end
	end

	always_comb begin
		res_n.negative = neg_n;
		if (err_n != ST_OK) begin
			res_n.status = err_n;
		end else if (!digits_n) begin
			res_n.status = sign_n ? ST_EMPTY_SIGN : ST_EMPTY;
		end else begin
			res_n.status = ST_OK;
		end
		res_n.magnitude = (res_n.status == ST_OK) ? acc_n : 64'd0;
	end

	// string state, cleared after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= 64'd0;
			neg_q    <= 1'b0;
			first_q  <= 1'b1;
			digits_q <= 1'b0;
			sign_q   <= 1'b0;
			err_q    <= ST_OK;
		end else if (adv) begin
			if (last_s1) begin
				acc_q    <= 64'd0;
				neg_q    <= 1'b0;
				first_q  <= 1'b1;
				digits_q <= 1'b0;
				sign_q   <= 1'b0;
				err_q    <= ST_OK;
			end else begin
				acc_q    <= acc_n;
				neg_q    <= neg_n;
				first_q  <= first_q && !has_char_s1;
				digits_q <= digits_n;
				sign_q   <= sign_n;
				err_q    <= err_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_s2 <= res_n;
		end
	end

	`DTTI_ASSERT_IMPL(a_err_zero_value, clk, arst_n, res_valid_s2 && res_s2.status != ST_OK, res_s2.magnitude == 64'd0)
	`DTTI_ASSERT_NEXT(a_clear_after_end, clk, arst_n, adv && last_s1, first_q && err_q == ST_OK && acc_q == 64'd0)
	`DTTI_ASSERT_NEXT(a_err_sticky, clk, arst_n, err_q != ST_OK && !(adv && last_s1), $stable(err_q))
	`DTTI_ASSERT_IMPL(a_neg_needs_sign, clk, arst_n, neg_q, sign_q)

endmodule

// ===== hdl/dtti_emit.sv =====
// final negation and output register with skid entry
// depends on dtti_pkg and dtti_ifs
module dtti_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  dtti_pkg::raw_res_t res,
	input  logic               res_valid,
	output logic               res_ready,
	dtti_res_if.source         results
);
	import dtti_pkg::*;

	logic     main_v_q;
	logic     skid_v_q;
	out_res_t main_q;
	out_res_t skid_q;
	out_res_t fin;
	logic     drain;

	assign fin.value_bits = res.negative ? (64'd0 - res.magnitude) : res.magnitude;
	assign fin.status     = res.status;
	assign res_ready      = !skid_v_q;
	assign drain          = !main_v_q || results.ready;

	assign results.valid      = main_v_q;
	assign results.value_bits = main_q.value_bits;
	assign results.status     = main_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= res_valid;
			end
		end else if (res_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			main_q <= skid_v_q ? skid_q : fin;
		end
		if (!drain && res_valid && !skid_v_q) begin
			skid_q <= fin;
		end
	end

endmodule

// ===== hdl/decimal_text_to_int64.sv =====
// Decimal text to 64-bit integer. Takes one character item per cycle, except
// that an item with last set is held while its result slot is still full, and
// gives one result (value_bits and status) for each item with last set, through
// the raw result register of dtti_parse and the output register of dtti_emit.
// The accumulator update (multiply by ten, add the digit and compare against the
// exact limit) is combinational. A stalled output is absorbed by a one-entry skid
// register. Depends on dtti_pkg, dtti_ifs, dtti_parse and dtti_emit.
module decimal_text_to_int64 (
	input logic        clk,
	input logic        arst_n,
	dtti_char_if.sink  chars,
	dtti_cfg_if.sink   cfg,
	dtti_res_if.source results
);
	import dtti_pkg::*;

	raw_res_t res;
	logic     res_valid;
	logic     res_ready;

	dtti_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.cfg       (cfg),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	dtti_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.results   (results)
	);

endmodule
